// ===== rtl/core/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg: shared types and constants for the rarest piece selector
// Command and result transaction layouts, operation codes, register map
// and the default sizes of the piece table.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

    // Default sizes of the piece table
    localparam int NUM_PIECES_DEF  = 1024;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int TOTAL_W = 11;
    localparam int PIECE_W = 10;
    localparam int POS_W   = 7;
    localparam int RAND_W  = 16;

    // Configuration register map (word index)
    localparam logic REG_PIECE_TOTAL = 1'b0;

    localparam logic [TOTAL_W-1:0] PIECE_TOTAL_RESET = 11'd1024;

    // Operation codes; the fourth code is unused and does nothing
    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_MARK   = 2'd1,
        FUNC_SELECT = 2'd2
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [POS_W-1:0]   byte_pos;
        logic [7:0]         peer_bits;
        logic [PIECE_W-1:0] piece_in;
        logic [RAND_W-1:0]  random_value;
    } cmd_t;

    typedef struct packed {
        logic [PIECE_W-1:0] piece_out;
        logic               found;
        logic               all_done;
        logic               bad_index;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rarest_piece_selector.sv =====
// ----------------------------------------------------------------------------
// rarest_piece_selector: rarest-first piece selection engine
// Keeps a saturating availability count and an owned flag per piece in one
// synchronous table, and serves bitfield updates, owned marks and rarest
// piece selection one command at a time.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears for one cycle with done high and must be captured then. Timing is
// set by the walk over the piece table (one entry read per cycle): a bitfield
// byte walks the pieces of that byte, a select makes a minimum pass, runs a
// remainder unit, then a tie pass that stops at the chosen piece, and a mark
// writes the piece, plus a walk up to the next unowned piece when the lowest
// unowned piece is marked. After reset the table is cleared one entry per
// cycle with busy high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module rarest_piece_selector #(
    parameter int NUM_PIECES  = rps_pkg::NUM_PIECES_DEF,
    parameter int COUNT_WIDTH = rps_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // command channel
    input  wire logic          start,
    input  wire rps_pkg::cmd_t cmd,
    output logic               busy,
    // result channel
    output logic               done,
    output rps_pkg::res_t      result,
    // configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(NUM_PIECES);
    localparam int TW    = rps_pkg::TOTAL_W;
    // Largest effective total: the table size, limited to what the register holds
    localparam int NCAP  = (NUM_PIECES > 2047) ? 2047 : NUM_PIECES;
    localparam logic [TW-1:0] NCAP_T = TW'(NCAP);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIECES - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_ADD   = 7'b0000100,
        ST_LOW   = 7'b0001000,
        ST_MIN   = 7'b0010000,
        ST_MOD   = 7'b0100000,
        ST_PICK  = 7'b1000000
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    rps_pkg::cmd_t          cmd_reg, cmd_next;
    logic [TW-1:0]          piece_total_reg;
    logic [TW-1:0]          iss_reg, iss_next;
    logic [TW-1:0]          limit_reg, limit_next;
    logic [TW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [TW-1:0]          low_reg, low_next;
    logic [COUNT_WIDTH-1:0] min_reg, min_next;
    logic [TW-1:0]          ties_reg, ties_next;
    logic                   any_reg, any_next;
    logic [TW-1:0]          rem_reg, rem_next;
    logic [3:0]             bit_cnt_reg, bit_cnt_next;
    rps_pkg::res_t          res_reg, res_next;
    logic                   done_reg, done_next;

    // Piece table: owned flag on top of the availability count
    logic [COUNT_WIDTH:0]   mem [NUM_PIECES];
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_WIDTH:0]   rd_q;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [COUNT_WIDTH:0]   wr_data;

    logic                   rd_owned;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [TW-1:0]          eff;
    logic                   scan_end;
    logic                   accept;
    logic [TW-1:0]          add_end;
    logic [TW:0]            rem_shift;
    logic                   peer_bit;

    assign rd_owned = rd_q[COUNT_WIDTH];
    assign rd_cnt   = rd_q[COUNT_WIDTH-1:0];
    assign eff      = (piece_total_reg > NCAP_T) ? NCAP_T : piece_total_reg;
    assign scan_end = (iss_reg >= limit_reg) && !rd_vld_reg;
    assign accept   = start && (state_reg == ST_IDLE);
    assign add_end  = TW'({cmd_reg.byte_pos, 3'b000}) + TW'(8);
    assign rem_shift = {rem_reg, cmd_reg.random_value[bit_cnt_reg]};
    assign peer_bit  = cmd_reg.peer_bits[~rd_idx_reg[2:0]];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rps_pkg::REG_PIECE_TOTAL) ? 32'(piece_total_reg) : '0;

    // Capture register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_total_reg <= rps_pkg::PIECE_TOTAL_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr[2] == rps_pkg::REG_PIECE_TOTAL)
        begin
            piece_total_reg <= pwdata[TW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Piece table
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd_next     = cmd_reg;
        iss_next     = iss_reg;
        limit_next   = limit_reg;
        rd_idx_next  = rd_idx_reg;
        rd_vld_next  = 1'b0;
        low_next     = low_reg;
        min_next     = min_reg;
        ties_next    = ties_reg;
        any_next     = any_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = IDX_W'(iss_reg);
        wr_en        = 1'b0;
        wr_addr      = IDX_W'(rd_idx_reg);
        wr_data      = '0;

        // Issue one table read per cycle while walking
        if (state_reg == ST_ADD || state_reg == ST_LOW ||
            state_reg == ST_MIN || state_reg == ST_PICK)
        begin
            if (iss_reg < limit_reg)
            begin
                rd_en       = 1'b1;
                iss_next    = iss_reg + TW'(1);
                rd_vld_next = 1'b1;
                rd_idx_next = iss_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    unique case (cmd.func)
                        rps_pkg::FUNC_ADD:
                        begin
                            iss_next   = TW'({cmd.byte_pos, 3'b000});
                            limit_next = eff;
                            state_next = ST_ADD;
                        end
                        rps_pkg::FUNC_MARK:
                        begin
                            if (TW'(cmd.piece_in) >= eff)
                            begin
                                res_next.bad_index = 1'b1;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                // Own the piece and drop its count
                                wr_en   = 1'b1;
                                wr_addr = IDX_W'(cmd.piece_in);
                                wr_data = {1'b1, {COUNT_WIDTH{1'b0}}};
                                if (TW'(cmd.piece_in) == low_reg)
                                begin
                                    iss_next   = TW'(cmd.piece_in) + TW'(1);
                                    limit_next = NCAP_T;
                                    state_next = ST_LOW;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        rps_pkg::FUNC_SELECT:
                        begin
                            iss_next   = '0;
                            limit_next = eff;
                            any_next   = 1'b0;
                            ties_next  = '0;
                            min_next   = '0;
                            state_next = ST_MIN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                // Bump set, unowned, unsaturated pieces of this byte
                if (rd_vld_reg && peer_bit && !rd_owned && rd_cnt != COUNT_MAX)
                begin
                    wr_en   = 1'b1;
                    wr_addr = IDX_W'(rd_idx_reg);
                    wr_data = {1'b0, rd_cnt + COUNT_WIDTH'(1)};
                end
                if (iss_reg >= add_end)
                begin
                    rd_en       = 1'b0;
                    iss_next    = iss_reg;
                    rd_vld_next = 1'b0;
                end
                if ((iss_reg >= limit_reg || iss_reg >= add_end) && !rd_vld_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_LOW:
            begin
                // Advance the lowest unowned index
                if (rd_vld_reg && !rd_owned)
                begin
                    low_next    = rd_idx_reg;
                    rd_vld_next = 1'b0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (scan_end)
                begin
                    low_next   = NCAP_T;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_MIN:
            begin
                // Track least nonzero count and how many pieces share it
                if (rd_vld_reg && !rd_owned && rd_cnt != '0)
                begin
                    if (!any_reg || rd_cnt < min_reg)
                    begin
                        min_next  = rd_cnt;
                        ties_next = TW'(1);
                        any_next  = 1'b1;
                    end
                    else if (rd_cnt == min_reg)
                    begin
                        ties_next = ties_reg + TW'(1);
                    end
                end
                if (scan_end)
                begin
                    if (any_reg)
                    begin
                        rem_next     = '0;
                        bit_cnt_next = 4'd15;
                        state_next   = ST_MOD;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_MOD:
            begin
                // Restoring remainder, one bit of the random value per cycle
                if (rem_shift >= {1'b0, ties_reg})
                begin
                    rem_next = TW'(rem_shift - {1'b0, ties_reg});
                end
                else
                begin
                    rem_next = TW'(rem_shift);
                end
                bit_cnt_next = bit_cnt_reg - 4'd1;
                if (bit_cnt_reg == 4'd0)
                begin
                    iss_next   = '0;
                    limit_next = eff;
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                // Count down through the tied pieces to the chosen one
                if (rd_vld_reg && !rd_owned && rd_cnt == min_reg)
                begin
                    if (rem_reg == '0)
                    begin
                        res_next.piece_out = rps_pkg::PIECE_W'(rd_idx_reg);
                        res_next.found     = 1'b1;
                        rd_vld_next        = 1'b0;
                        done_next          = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        rem_next = rem_reg - TW'(1);
                    end
                end
                else if (scan_end)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Completion reflects this transaction's update
        if (done_next)
        begin
            res_next.all_done = (low_next >= eff);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
            low_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_vld_reg  <= rd_vld_next;
            low_reg     <= low_next;
            done_reg    <= done_next;
        end
    end

    // Payload and walk state
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        iss_reg     <= iss_next;
        limit_reg   <= limit_next;
        rd_idx_reg  <= rd_idx_next;
        min_reg     <= min_next;
        ties_reg    <= ties_next;
        any_reg     <= any_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        res_reg     <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE)
        else $error("result issued while a command is still running");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither started nor completed");

    a_found_select: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.found) |-> (!res_reg.bad_index && cmd_reg.func == rps_pkg::FUNC_SELECT))
        else $error("piece reported found outside a select");

    a_low_range: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= NCAP_T)
        else $error("lowest unowned index beyond the table");

    a_ties_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD || state_reg == ST_PICK) |-> ties_reg != '0)
        else $error("tie pick entered with no candidates");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rarest-first piece selector verification
// Drives bitfield bytes, owned marks, rarest selections and the unused code
// through the start/busy command port. A behavioral copy of the piece table
// predicts every result, and each done strobe is checked field by field.
// The piece total is reprogrammed over APB between phases and read back.
// ----------------------------------------------------------------------------

module testbench;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam bit [rps_pkg::COUNT_WIDTH_DEF-1:0] COUNT_MAX = '1;

    logic                 clk;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    rps_pkg::cmd_t        cmd     = '0;
    logic                 busy;
    logic                 done;
    rps_pkg::res_t        result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [2:0]           paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Shadow copy of the piece table and the programmed total
    bit [rps_pkg::COUNT_WIDTH_DEF-1:0] peer_count [rps_pkg::NUM_PIECES_DEF];
    bit                                piece_owned [rps_pkg::NUM_PIECES_DEF];
    logic [rps_pkg::TOTAL_W-1:0]       total_setting = rps_pkg::PIECE_TOTAL_RESET;

    rps_pkg::res_t pending_results [$];
    int            error_count = 0;
    int            quiet_left  = 0;

    rarest_piece_selector u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Generate a 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int effective_total();
        return (int'(total_setting) > rps_pkg::NUM_PIECES_DEF) ?
               rps_pkg::NUM_PIECES_DEF : int'(total_setting);
    endfunction

    // Apply one command to the shadow table and return the result it yields
    function automatic rps_pkg::res_t apply_command(input rps_pkg::cmd_t c);
        rps_pkg::res_t r;
        int            n;
        int            p;
        int            lowest;
        int            ties;
        int            pick;
        r = '0;
        n = effective_total();
        lowest = 0;
        ties = 0;
        case (c.func)
            rps_pkg::FUNC_ADD:
            begin
                // Bit 7 maps to the lowest piece of the byte
                for (int b = 0; b < 8; b++)
                begin
                    p = int'(c.byte_pos) * 8 + b;
                    if (p < n && c.peer_bits[7 - b] && !piece_owned[p]
                        && peer_count[p] != COUNT_MAX)
                        peer_count[p] = peer_count[p] + 1'b1;
                end
            end
            rps_pkg::FUNC_MARK:
            begin
                if (int'(c.piece_in) >= n)
                    r.bad_index = 1'b1;
                else
                begin
                    piece_owned[c.piece_in] = 1'b1;
                    peer_count[c.piece_in] = '0;
                end
            end
            rps_pkg::FUNC_SELECT:
            begin
                // Find the least nonzero count among unowned pieces
                for (int i = 0; i < n; i++)
                begin
                    if (!piece_owned[i] && peer_count[i] != 0)
                    begin
                        if (ties == 0 || int'(peer_count[i]) < lowest)
                        begin
                            lowest = int'(peer_count[i]);
                            ties = 1;
                        end
                        else if (int'(peer_count[i]) == lowest)
                            ties++;
                    end
                end
                // Walk the ties again and stop at the random one
                if (ties != 0)
                begin
                    pick = int'(c.random_value) % ties;
                    for (int i = 0; i < n; i++)
                    begin
                        if (!piece_owned[i] && int'(peer_count[i]) == lowest)
                        begin
                            if (pick == 0)
                            begin
                                r.piece_out = rps_pkg::PIECE_W'(i);
                                r.found = 1'b1;
                                break;
                            end
                            pick--;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.all_done = 1'b1;
        for (int i = 0; i < n; i++)
            if (!piece_owned[i])
                r.all_done = 1'b0;
        return r;
    endfunction

    function automatic rps_pkg::cmd_t command(input rps_pkg::func_t f, input int pos,
                                              input int bits, input int pin,
                                              input int rnd);
        rps_pkg::cmd_t c;
        c.func = f;
        c.byte_pos = rps_pkg::POS_W'(pos);
        c.peer_bits = 8'(bits);
        c.piece_in = rps_pkg::PIECE_W'(pin);
        c.random_value = rps_pkg::RAND_W'(rnd);
        return c;
    endfunction

    // Mostly meaningful commands; a tenth of positions and indexes land anywhere
    function automatic rps_pkg::cmd_t random_command();
        rps_pkg::cmd_t c;
        int            n;
        int            kind;
        n = effective_total();
        kind = $urandom_range(0, 99);
        c.func = rps_pkg::FUNC_ADD;
        c.byte_pos = rps_pkg::POS_W'($urandom);
        c.peer_bits = 8'($urandom);
        c.piece_in = rps_pkg::PIECE_W'($urandom);
        c.random_value = rps_pkg::RAND_W'($urandom);
        if (kind < 55)
        begin
            if (n > 0 && $urandom_range(0, 9) != 0)
                c.byte_pos = rps_pkg::POS_W'($urandom_range(0, (n - 1) / 8));
        end
        else if (kind < 70)
        begin
            c.func = rps_pkg::FUNC_MARK;
            if (n > 0 && $urandom_range(0, 9) != 0)
                c.piece_in = rps_pkg::PIECE_W'($urandom_range(0, n - 1));
        end
        else if (kind < 94)
            c.func = rps_pkg::FUNC_SELECT;
        else
            c.func = rps_pkg::func_t'(FUNC_UNUSED);
        return c;
    endfunction

    // Idle cycles before the next command: mostly short, a few long, some bursts
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            quiet_left = $urandom_range(8, 24);
            return 0;
        end
        if (r < 40)
            return 0;
        if (r < 85)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Issue one command transaction and record its expected result
    task automatic send_command(input rps_pkg::cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.insert(pending_results.size(), apply_command(c));
    endtask

    // Drop start and hold until every result is in and the block is free
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Write the piece total over APB, then read it back
    task automatic program_total(input logic [rps_pkg::TOTAL_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rps_pkg::REG_PIECE_TOTAL, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        total_setting = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[rps_pkg::TOTAL_W-1:0] !== value)
        begin
            error_count++;
            $display("%0t: piece_total readback expected %0d actual %0d",
                     $time, value, prdata[rps_pkg::TOTAL_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each result transaction against the oldest prediction
    always @(posedge clk)
    begin : result_check
        rps_pkg::res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none pending, expected nothing actual %h",
                         $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("piece_out", 32'(want.piece_out), 32'(result.piece_out));
                check_field("found", 32'(want.found), 32'(result.found));
                check_field("all_done", 32'(want.all_done), 32'(result.all_done));
                check_field("bad_index", 32'(want.bad_index), 32'(result.bad_index));
            end
        end
    end

    // Select from an empty table at the reset total
    task automatic test_empty_table();
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 16'hFFFF));
    endtask

    // Check bit order within a byte and tie breaking at both ends of the table
    task automatic test_bit_order();
        send_command(command(rps_pkg::FUNC_ADD, 0, 8'h80, 0, 0));
        send_command(command(rps_pkg::FUNC_ADD, 0, 8'h01, 0, 0));
        send_command(command(rps_pkg::FUNC_ADD, 127, 8'hFF, 0, 0));
        send_command(command(rps_pkg::FUNC_ADD, 64, 8'h55, 0, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 16'hFFFF));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 7));
    endtask

    // Owned pieces lose their count, ignore bits and drop out of selection
    task automatic test_owned_pieces();
        send_command(command(rps_pkg::FUNC_MARK, 0, 0, 1023, 0));
        send_command(command(rps_pkg::FUNC_MARK, 0, 0, 1023, 0));
        send_command(command(rps_pkg::FUNC_ADD, 127, 8'hFF, 0, 0));
        send_command(command(rps_pkg::FUNC_MARK, 0, 0, 7, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 1));
    endtask

    task automatic test_unused_code();
        send_command(command(rps_pkg::func_t'(FUNC_UNUSED), 127, 8'hFF, 1023, 16'hFFFF));
    endtask

    // No pieces in use: everything is done and every mark is out of range
    task automatic test_zero_total();
        program_total('0);
        send_command(command(rps_pkg::FUNC_ADD, 0, 8'hFF, 0, 0));
        send_command(command(rps_pkg::FUNC_MARK, 0, 0, 0, 0));
        send_command(command(rps_pkg::FUNC_MARK, 0, 0, 1023, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 16'hFFFF));
    endtask

    // A total past the table size saturates to the table size
    task automatic test_oversize_total();
        program_total('1);
        send_command(command(rps_pkg::FUNC_ADD, 127, 8'hFF, 0, 0));
        send_command(command(rps_pkg::FUNC_MARK, 0, 0, 1022, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 0));
    endtask

    // One piece in use: only bit 7 of byte zero counts, marking it completes
    task automatic test_single_piece();
        program_total(rps_pkg::TOTAL_W'(1));
        send_command(command(rps_pkg::FUNC_ADD, 0, 8'hFF, 0, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 0));
        send_command(command(rps_pkg::FUNC_MARK, 0, 0, 1, 0));
        send_command(command(rps_pkg::FUNC_MARK, 0, 0, 0, 0));
        send_command(command(rps_pkg::FUNC_SELECT, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(input logic [rps_pkg::TOTAL_W-1:0] total,
                                       input int count);
        program_total(total);
        repeat (count)
            send_command(random_command());
    endtask

    // Run the test sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_bit_order();
        test_owned_pieces();
        test_unused_code();
        test_zero_total();
        test_oversize_total();
        test_single_piece();
        test_random_traffic(rps_pkg::TOTAL_W'(1024), 45);
        test_random_traffic(rps_pkg::TOTAL_W'($urandom_range(2, 200)), 60);
        test_random_traffic('1, 25);
        test_random_traffic(rps_pkg::TOTAL_W'(9), 50);
        test_random_traffic(rps_pkg::TOTAL_W'(1023), 40);
        test_random_traffic(rps_pkg::TOTAL_W'(3), 40);
        test_random_traffic(rps_pkg::TOTAL_W'(1), 10);
        wait_idle();
        repeat (64) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
